>>> src/sorted_software_timer_queue_top_macros.svh
// Assertion macros used by the checker file.
`ifndef SORTED_SOFTWARE_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_SOFTWARE_TIMER_QUEUE_TOP_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SSTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define SSTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

>>> src/sstq_pkg.sv
package sstq_pkg;
  localparam int NumTimers = 16;
  localparam int IdW = 4;
  localparam int TickW = 32;
  localparam int CntW = 5;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STOP = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [1:0] EV_ACK = 2'd0;
  localparam logic [1:0] EV_EXPIRED = 2'd1;
  localparam logic [1:0] EV_TICK_DONE = 2'd2;
  localparam logic [1:0] EV_STATUS = 2'd3;

  localparam logic [1:0] ST_UNUSED = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] timer_id;
    logic periodic;
    logic [31:0] period;
  } in_req_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] timer_id_res;
    logic [1:0] timer_state;
    logic [31:0] remaining;
    logic last;
  } out_res_t;

  // Operation broadcast to every cell of the sorted chain.
  localparam logic [1:0] CH_NOP = 2'd0;
  localparam logic [1:0] CH_INSERT = 2'd1;
  localparam logic [1:0] CH_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [IdW-1:0] id;
    logic [TickW-1:0] left;
  } chain_ctl_t;
endpackage

>>> src/sstq_cell.sv
module sstq_cell
  import sstq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  chain_ctl_t ctl,
  input  logic [TickW-1:0] now,
  input  logic prev_valid,
  input  logic prev_before,
  input  logic [IdW-1:0] prev_id,
  input  logic [TickW-1:0] prev_dl,
  input  logic prev_match,
  input  logic next_valid,
  input  logic [IdW-1:0] next_id,
  input  logic [TickW-1:0] next_dl,
  output logic valid,
  output logic ahead,
  output logic match_seen,
  output logic [IdW-1:0] id,
  output logic [TickW-1:0] dl
);
  logic valid_r, valid_nxt;
  logic [IdW-1:0] id_r, id_nxt;
  logic [TickW-1:0] dl_r, dl_nxt;
  logic [TickW-1:0] left;
  logic self_match;

  assign left = dl_r - now;
  // Set when this cell's entry stays ahead of the new entry.
  assign ahead = valid_r && (left < ctl.left);
  assign self_match = valid_r && (id_r == ctl.id);
  assign match_seen = prev_match || self_match;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt = id_r;
    dl_nxt = dl_r;
    case (ctl.op)
      CH_INSERT: begin
        if (!ahead) begin
          if (prev_before) begin
            valid_nxt = 1'b1;
            id_nxt = ctl.id;
            dl_nxt = ctl.left + now;
          end else begin
            valid_nxt = prev_valid;
            id_nxt = prev_id;
            dl_nxt = prev_dl;
          end
        end
      end
      CH_REMOVE: begin
        if (match_seen) begin
          valid_nxt = next_valid;
          id_nxt = next_id;
          dl_nxt = next_dl;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

  assign valid = valid_r;
  assign id = id_r;
  assign dl = dl_r;
endmodule

>>> src/sstq_chain.sv
module sstq_chain
  import sstq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  chain_ctl_t ctl,
  input  logic [TickW-1:0] now,
  output logic head_valid,
  output logic [IdW-1:0] head_id,
  output logic [TickW-1:0] head_dl
);
  logic [NumTimers-1:0] v, bf, ms;
  logic [IdW-1:0] ids [NumTimers];
  logic [TickW-1:0] dls [NumTimers];

  for (genvar i = 0; i < NumTimers; i++) begin : g_cell
    logic pv, pb, pm, nv;
    logic [IdW-1:0] pid, nid;
    logic [TickW-1:0] pdl, ndl;
    if (i == 0) begin : g_first
      assign pv = 1'b0;
      assign pb = 1'b1;
      assign pm = 1'b0;
      assign pid = '0;
      assign pdl = '0;
    end else begin : g_mid
      assign pv = v[i-1];
      assign pb = bf[i-1];
      assign pm = ms[i-1];
      assign pid = ids[i-1];
      assign pdl = dls[i-1];
    end
    if (i == NumTimers - 1) begin : g_last
      assign nv = 1'b0;
      assign nid = '0;
      assign ndl = '0;
    end else begin : g_nmid
      assign nv = v[i+1];
      assign nid = ids[i+1];
      assign ndl = dls[i+1];
    end
    sstq_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .now(now),
      .prev_valid(pv), .prev_before(pb), .prev_id(pid), .prev_dl(pdl),
      .prev_match(pm), .next_valid(nv), .next_id(nid), .next_dl(ndl),
      .valid(v[i]), .ahead(bf[i]), .match_seen(ms[i]), .id(ids[i]), .dl(dls[i])
    );
  end

  assign head_valid = v[0];
  assign head_id = ids[0];
  assign head_dl = dls[0];
endmodule

>>> src/sorted_software_timer_queue_top.sv
// Sorted software timer queue: sixteen one-shot or periodic timers.
// Requests enter on in_req at a clock edge where start is high and busy is
// low; each request produces results on out_res, one at a time, each marked
// by out_valid for a single cycle. The receiver cannot stall; results must be
// taken when shown. out_res.last marks the final result of a request.
// Create, start, stop and query requests pass through the S_CMD state, which
// updates the timer and the sorted chain and registers the result; the result
// is shown in the cycle after S_CMD. Busy stays high while the result is
// shown, so a new command request is accepted only after it has been shown.
// A tick request advances the tick counter and, in S_TICK, pops each expiring
// timer; a periodic timer is reinserted in S_RELINK before the next check.
// When no timer is due, S_DONE presents the tick-done result. The sorted
// list is a chain of sixteen cells: on an insert the cells behind the new
// entry shift back by one, and on a removal the cells from the removed entry
// on shift forward by one. Synchronous active-low reset clears the tick
// counter, all timer states and the chain; busy is low right after reset.
module sorted_software_timer_queue_top
  import sstq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_req_t in_req,
  output logic out_valid,
  output out_res_t out_res
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_RELINK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  in_req_t req_r, req_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [1:0] status_r [NumTimers];
  logic [1:0] status_nxt [NumTimers];
  logic [TickW-1:0] period_r [NumTimers];
  logic per_r [NumTimers];
  logic out_valid_r, out_valid_nxt;
  out_res_t res_r, res_nxt;
  logic [IdW-1:0] pend_r, pend_nxt;
  chain_ctl_t ctl;
  logic head_valid;
  logic [IdW-1:0] head_id;
  logic [TickW-1:0] head_dl;
  logic [1:0] st_cur;
  logic wr_period;

  sstq_chain u_chain (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .now(tick_r),
    .head_valid(head_valid), .head_id(head_id), .head_dl(head_dl)
  );

  assign st_cur = status_r[req_r.timer_id];

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    tick_nxt = tick_r;
    status_nxt = status_r;
    out_valid_nxt = 1'b0;
    res_nxt = res_r;
    pend_nxt = pend_r;
    ctl = '0;
    wr_period = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !out_valid_r) begin
          req_nxt = in_req;
          if (in_req.command == CMD_TICK) begin
            tick_nxt = tick_r + 1'b1;
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD: begin
        res_nxt = '0;
        res_nxt.event_kind = EV_ACK;
        res_nxt.timer_id_res = req_r.timer_id;
        res_nxt.last = 1'b1;
        res_nxt.timer_state = st_cur;
        case (req_r.command)
          CMD_CREATE: begin
            if (req_r.period != '0 && st_cur != ST_RUNNING) begin
              wr_period = 1'b1;
              status_nxt[req_r.timer_id] = ST_CREATED;
              res_nxt.timer_state = ST_CREATED;
            end
          end
          CMD_START: begin
            if (st_cur == ST_CREATED || st_cur == ST_FINISHED) begin
              status_nxt[req_r.timer_id] = ST_RUNNING;
              res_nxt.timer_state = ST_RUNNING;
              ctl.op = CH_INSERT;
              ctl.id = req_r.timer_id;
              ctl.left = period_r[req_r.timer_id];
            end
          end
          CMD_STOP: begin
            if (st_cur == ST_CREATED || st_cur == ST_RUNNING) begin
              status_nxt[req_r.timer_id] = ST_FINISHED;
              res_nxt.timer_state = ST_FINISHED;
              if (st_cur == ST_RUNNING) begin
                ctl.op = CH_REMOVE;
                ctl.id = req_r.timer_id;
              end
            end
          end
          CMD_QUERY: begin
            res_nxt.event_kind = EV_STATUS;
          end
          default: ;
        endcase
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (head_valid && head_dl == tick_r) begin
          ctl.op = CH_REMOVE;
          ctl.id = head_id;
          res_nxt = '0;
          res_nxt.event_kind = EV_EXPIRED;
          res_nxt.timer_id_res = head_id;
          if (per_r[head_id]) begin
            status_nxt[head_id] = ST_RUNNING;
            res_nxt.timer_state = ST_RUNNING;
            pend_nxt = head_id;
            state_nxt = S_RELINK;
          end else begin
            status_nxt[head_id] = ST_FINISHED;
            res_nxt.timer_state = ST_FINISHED;
          end
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RELINK: begin
        ctl.op = CH_INSERT;
        ctl.id = pend_r;
        ctl.left = period_r[pend_r];
        state_nxt = S_TICK;
      end
      S_DONE: begin
        res_nxt = '0;
        res_nxt.event_kind = EV_TICK_DONE;
        res_nxt.last = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        status_r[i] <= ST_UNUSED;
      end
    end else begin
      state_r <= state_nxt;
      tick_r <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      status_r <= status_nxt;
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    pend_r <= pend_nxt;
    if (wr_period) begin
      period_r[req_r.timer_id] <= req_r.period;
      per_r[req_r.timer_id] <= req_r.periodic;
    end
  end

  // The query reply of a running timer reads its deadline from a copy of the chain deadlines written on every insert.
  logic [TickW-1:0] q_left;
  logic [TickW-1:0] dl_r [NumTimers];
  always_ff @(posedge clk) begin
    if (ctl.op == CH_INSERT) begin
      dl_r[ctl.id] <= ctl.left + tick_r;
    end
  end
  assign q_left = dl_r[res_r.timer_id_res] - tick_r;

  always_comb begin
    out_res = res_r;
    if (res_r.event_kind == EV_STATUS && res_r.timer_state == ST_RUNNING) begin
      out_res.remaining = q_left;
    end
  end

  assign out_valid = out_valid_r;
  assign busy = (state_r != S_IDLE) || out_valid_r;
endmodule

>>> src/sstq_checker.sv
`include "sorted_software_timer_queue_top_macros.svh"
module sstq_checker
  import sstq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_res_t out_res
);
  `SSTQ_ASSERT_NXT(a_acc_busy, clk, rst_n, start && !busy, busy)
  `SSTQ_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, busy)
  `SSTQ_ASSERT_IMP(a_done_last, clk, rst_n, out_valid && out_res.event_kind == EV_TICK_DONE, out_res.last)
  `SSTQ_ASSERT_IMP(a_exp_notlast, clk, rst_n, out_valid && out_res.event_kind == EV_EXPIRED, !out_res.last)
  `SSTQ_ASSERT_NXT(a_last_free, clk, rst_n, out_valid && out_res.last, !busy)
endmodule

bind sorted_software_timer_queue_top sstq_checker u_sstq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_res(out_res)
);
